>>> sv/hkfs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed key failure set package
// Shared types, constants and controller encodings for the FNV-1a membership
// set.
// ----------------------------------------------------------------------------
package hkfs_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [63:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
  // The prime is 2^40 + 2^8 + 0xB3.
  localparam logic [7:0] FNV_PRIME_LO = 8'hB3;

  typedef struct packed {
    logic       kind;
    logic [7:0] key_byte;
    logic       last_byte;
    logic       insert_request;
  } hkfs_in_t;

  typedef struct packed {
    logic found;
    logic inserted;
    logic table_full;
  } hkfs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_READ,
    ST_CMP,
    ST_DECIDE
  } hkfs_state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic mix;
    logic scan_start;
    logic rd;
    logic cmp;
    logic commit;
  } hkfs_cmd_t;

  typedef struct packed {
    logic last;
    logic cnt_zero;
    logic scan_done;
    logic out_free;
  } hkfs_status_t;

endpackage

`default_nettype wire

>>> sv/hashed_key_failure_set.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed key failure set
// Folds key bytes into a 64-bit FNV-1a hash and keeps a small set of hashes.
//
//   Channel | Signals                              | Word
//   --------+--------------------------------------+-----------
//   in      | in_valid_i, in_stall_o, in_word_i    | hkfs_in_t
//   out     | out_valid_o, out_stall_i, out_word_o | hkfs_out_t
//
// A clear word is taken in idle; any key byte is loaded in idle and mixed in
// mix. A last byte then reads and compares stored entries up to and including
// a match, one read state and one compare state each, then goes to decide.
// Reset empties the table and loads the offset basis; no clearing pass.
// A result waits in the output register; a later last byte waits in its decide
// state, with the input stalled, until that register drains.
// ----------------------------------------------------------------------------
module hashed_key_failure_set (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  hkfs_pkg::hkfs_in_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output hkfs_pkg::hkfs_out_t out_word_o
);
  import hkfs_pkg::*;

  hkfs_cmd_t    cmd;
  hkfs_status_t status;

  hkfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_word_i.kind),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hkfs_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

>>> sv/hkfs_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed key failure set controller
// Sequences byte mixing, the table scan and the final decision.
// ----------------------------------------------------------------------------
module hkfs_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_stall_o,
  input  hkfs_pkg::hkfs_status_t status_i,
  output hkfs_pkg::hkfs_cmd_t    cmd_o
);
  import hkfs_pkg::*;

  hkfs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_kind_i) begin
          state_d = ST_MIX;
        end
      end
      ST_MIX: begin
        if (!status_i.last) begin
          state_d = ST_IDLE;
        end else if (status_i.cnt_zero) begin
          state_d = ST_DECIDE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        state_d = status_i.scan_done ? ST_DECIDE : ST_READ;
      end
      ST_DECIDE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.clear  = in_valid_i && in_kind_i;
        cmd_o.load   = in_valid_i && !in_kind_i;
      end
      ST_MIX: begin
        cmd_o.mix        = 1'b1;
        cmd_o.scan_start = 1'b1;
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
      end
      ST_DECIDE: begin
        cmd_o.commit = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/hkfs_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Hashed key failure set datapath
// Running hash, hash table memory, scan compare and output register.
// ----------------------------------------------------------------------------
module hkfs_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  hkfs_pkg::hkfs_in_t     in_word_i,
  input  hkfs_pkg::hkfs_cmd_t    cmd_i,
  output hkfs_pkg::hkfs_status_t status_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output hkfs_pkg::hkfs_out_t    out_word_o
);
  import hkfs_pkg::*;

  logic [63:0]      hash_q;
  logic [63:0]      x_q, x_d;
  logic [63:0]      p_q, p_d;
  logic             last_q;
  logic             ins_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] idx_q;
  logic             found_q;
  logic [63:0]      rdata_q;
  logic [63:0]      mem_q [TABLE_DEPTH];
  logic             out_valid_q;
  hkfs_out_t        out_q;

  logic [63:0]      mixed;
  logic             hit;
  logic             full;
  logic             do_insert;

  assign x_d       = hash_q ^ {56'd0, in_word_i.key_byte};
  assign p_d       = x_d * {56'd0, FNV_PRIME_LO};
  assign mixed     = (x_q << 40) + (x_q << 8) + p_q;
  assign hit       = (rdata_q == hash_q);
  assign full      = (count_q == CNT_W'(TABLE_DEPTH));
  assign do_insert = ins_q && !found_q && !full;

  assign status_o.last      = last_q;
  assign status_o.cnt_zero  = (count_q == '0);
  assign status_o.scan_done = hit || ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q    <= x_d;
      p_q    <= p_d;
      last_q <= in_word_i.last_byte;
      ins_q  <= in_word_i.insert_request;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[idx_q];
    end
    if (cmd_i.commit && do_insert) begin
      mem_q[count_q[IDX_W-1:0]] <= hash_q;
    end
    if (cmd_i.commit) begin
      out_q.found      <= found_q;
      out_q.inserted   <= do_insert;
      out_q.table_full <= full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q      <= FNV_BASIS;
      count_q     <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear || cmd_i.commit) begin
        hash_q <= FNV_BASIS;
      end else if (cmd_i.mix) begin
        hash_q <= mixed;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.commit && do_insert) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.scan_start) begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.cmp) begin
        idx_q <= idx_q + IDX_W'(1);
        if (hit) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire
